@@ rtl/trd_pkg.sv @@
// Package for the telegram response deframer.
// Holds the shared constants, verdict and kind codes and the result types.
// No dependencies; the parser, the result queue and the top level use it.
`default_nettype none

package trd_pkg;

  // Start byte layout.
  localparam logic [7:0] TYPE_MASK   = 8'hC0;
  localparam logic [7:0] TYPE_ANSWER = 8'h80;
  localparam logic [7:0] LEN_MASK    = 8'h0F;

  // Result kind codes.
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes.
  localparam logic [1:0] VERDICT_OK        = 2'd0;
  localparam logic [1:0] VERDICT_NOT_ANSW  = 2'd1;
  localparam logic [1:0] VERDICT_BAD_SUM   = 2'd2;
  localparam logic [1:0] VERDICT_TRUNCATED = 2'd3;

  // Default depth of the result queue.
  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [3:0] byte_index;
    logic [7:0] object_id;
    logic [7:0] node_id;
    logic [1:0] verdict;
    logic       last;
  } trd_result_t;

  // Results produced by one byte: cnt is 0, 1 or 2; res_a goes out first.
  typedef struct packed {
    logic [1:0]  cnt;
    trd_result_t res_a;
    trd_result_t res_b;
  } trd_push_t;

endpackage

`default_nettype wire

@@ rtl/trd_if.sv @@
// Handshake channel interfaces of the telegram response deframer.
// trd_in_if carries received bytes, trd_out_if carries result items.
// No dependencies.
`default_nettype none

interface trd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface trd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [3:0] byte_index;
  logic [7:0] object_id;
  logic [7:0] node_id;
  logic [1:0] verdict;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output byte_index,
                  output object_id, output node_id, output verdict, output last,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input byte_index,
                  input object_id, input node_id, input verdict, input last,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/trd_parser.sv @@
// Input register and frame parser of the telegram response deframer.
// Depends on trd_pkg and trd_in_if; hands its results to the result queue.
`default_nettype none

module trd_parser (
  input  wire              clk,
  input  wire              rst_n,
  trd_in_if.sink           in_ch,
  input  wire              room2,
  output trd_pkg::trd_push_t push
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_NODE = 3'd1;
  localparam logic [2:0] PH_OBJ  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CSHI = 3'd4;
  localparam logic [2:0] PH_CSLO = 3'd5;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic        fire;

  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  remain_r, remain_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  cs_hi_r, cs_hi_nxt;
  logic [7:0]  obj_r, obj_nxt;
  logic [7:0]  node_r, node_nxt;

  logic        trunc;
  logic        bad_type;
  logic [4:0]  remain_dec;
  logic [15:0] sum_add;
  trd_pkg::trd_result_t res_one;
  logic        have_one;

  assign fire        = s1_valid_r && room2;
  assign in_ch.ready = !s1_valid_r || room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_IDLE;
      remain_r   <= '0;
      pos_r      <= '0;
      sum_r      <= '0;
      cs_hi_r    <= '0;
      obj_r      <= '0;
      node_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (fire) begin
        phase_r  <= phase_nxt;
        remain_r <= remain_nxt;
        pos_r    <= pos_nxt;
        sum_r    <= sum_nxt;
        cs_hi_r  <= cs_hi_nxt;
        obj_r    <= obj_nxt;
        node_r   <= node_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r  <= in_ch.rx_byte;
      s1_start_r <= in_ch.frame_start;
    end
  end

  assign bad_type   = (s1_byte_r & trd_pkg::TYPE_MASK) != trd_pkg::TYPE_ANSWER;
  assign remain_dec = remain_r - 5'd1;
  assign sum_add    = sum_r + {8'd0, s1_byte_r};

  always_comb begin
    phase_nxt  = phase_r;
    remain_nxt = remain_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    cs_hi_nxt  = cs_hi_r;
    obj_nxt    = obj_r;
    node_nxt   = node_r;
    trunc      = 1'b0;
    have_one   = 1'b0;
    res_one    = '0;
    // The byte's own result is always the last one it causes.
    res_one.last = 1'b1;

    if (s1_start_r) begin
      // A start inside an unfinished frame closes that frame as truncated.
      trunc = (phase_r != PH_IDLE) && (phase_r <= PH_CSLO);
      if (bad_type) begin
        have_one        = 1'b1;
        res_one.kind    = trd_pkg::KIND_VERDICT;
        res_one.verdict = trd_pkg::VERDICT_NOT_ANSW;
        phase_nxt       = PH_IDLE;
      end else begin
        remain_nxt = {1'b0, s1_byte_r[3:0] & trd_pkg::LEN_MASK[3:0]} + 5'd1;
        pos_nxt    = '0;
        sum_nxt    = {8'd0, s1_byte_r};
        obj_nxt    = '0;
        node_nxt   = '0;
        phase_nxt  = PH_NODE;
      end
    end else begin
      unique case (phase_r)
        PH_NODE: begin
          node_nxt  = s1_byte_r;
          sum_nxt   = sum_add;
          phase_nxt = PH_OBJ;
        end
        PH_OBJ: begin
          obj_nxt   = s1_byte_r;
          sum_nxt   = sum_add;
          pos_nxt   = '0;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          have_one             = 1'b1;
          res_one.kind         = trd_pkg::KIND_DATA;
          res_one.payload_byte = s1_byte_r;
          res_one.byte_index   = pos_r;
          res_one.object_id    = obj_r;
          res_one.node_id      = node_r;
          sum_nxt              = sum_add;
          pos_nxt              = pos_r + 4'd1;
          remain_nxt           = remain_dec;
          if (remain_dec == 5'd0) begin
            phase_nxt = PH_CSHI;
          end
        end
        PH_CSHI: begin
          cs_hi_nxt = s1_byte_r;
          phase_nxt = PH_CSLO;
        end
        PH_CSLO: begin
          have_one          = 1'b1;
          res_one.kind      = trd_pkg::KIND_VERDICT;
          res_one.object_id = obj_r;
          res_one.node_id   = node_r;
          res_one.verdict   = ({cs_hi_r, s1_byte_r} == sum_r) ?
                              trd_pkg::VERDICT_OK : trd_pkg::VERDICT_BAD_SUM;
          phase_nxt         = PH_IDLE;
        end
        default: begin
          // Idle, and the unused codes: the byte is dropped.
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Order the results: a truncation verdict always goes first.
  always_comb begin
    push       = '0;
    if (trunc) begin
      push.res_a.kind      = trd_pkg::KIND_VERDICT;
      push.res_a.object_id = obj_r;
      push.res_a.node_id   = node_r;
      push.res_a.verdict   = trd_pkg::VERDICT_TRUNCATED;
      push.res_a.last      = !have_one;
      push.res_b           = res_one;
    end else begin
      push.res_a = res_one;
    end
    if (fire) begin
      push.cnt = {1'b0, trunc} + {1'b0, have_one};
    end
  end

`ifndef SYNTHESIS
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_CSLO)
    else $error("parser phase left the legal range");

  a_bad_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_start_r && bad_type |=> phase_r == PH_IDLE && $past(push.cnt) != 2'd0)
    else $error("rejected start byte did not return to idle with a verdict");
`endif

endmodule

`default_nettype wire

@@ rtl/trd_rqueue.sv @@
// Result queue of the telegram response deframer.
// Takes up to two results per cycle from the parser and drives the result channel.
// Depends on trd_pkg and trd_out_if.
`default_nettype none

module trd_rqueue #(
  parameter int DEPTH = trd_pkg::RES_DEPTH
) (
  input  wire               clk,
  input  wire               rst_n,
  input  trd_pkg::trd_push_t push,
  output logic              room2,
  trd_out_if.source         out_ch
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  trd_pkg::trd_result_t mem [DEPTH];

  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wptr_p1;
  logic [PTR_W-1:0] wptr_p2;
  logic             pop;
  trd_pkg::trd_result_t head;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wptr_p1 = ptr_inc(wptr_r);
  assign wptr_p2 = ptr_inc(wptr_p1);
  assign room2   = count_r <= CNT_W'(DEPTH - 2);
  assign pop     = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_r + CNT_W'(push.cnt) - CNT_W'(pop);
      if (pop) begin
        rptr_r <= ptr_inc(rptr_r);
      end
      if (push.cnt == 2'd1) begin
        wptr_r <= wptr_p1;
      end else if (push.cnt == 2'd2) begin
        wptr_r <= wptr_p2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wptr_r] <= push.res_a;
    end
    if (push.cnt == 2'd2) begin
      mem[wptr_p1] <= push.res_b;
    end
  end

  assign head                = mem[rptr_r];
  assign out_ch.valid        = count_r != '0;
  assign out_ch.kind         = head.kind;
  assign out_ch.payload_byte = head.payload_byte;
  assign out_ch.byte_index   = head.byte_index;
  assign out_ch.object_id    = head.object_id;
  assign out_ch.node_id      = head.node_id;
  assign out_ch.verdict      = head.verdict;
  assign out_ch.last         = head.last;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !room2 |-> push.cnt == 2'd0)
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH) && push.cnt != 2'd3)
    else $error("result queue count out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/telegram_response_deframer.sv @@
// Telegram response deframer: takes one received byte per request with a start
// flag, checks the answer type of the start byte, tracks node, object and data
// bytes of a length-prefixed frame, keeps a 16-bit wrapping byte sum and returns
// one request per data byte and one verdict request per frame (ok, not an
// answer, checksum mismatch, or truncated when a new start arrives early). A
// byte that both cuts off an open frame and carries a wrong answer type gives
// two requests, the truncation first; bytes outside a frame give none. The
// block accepts a byte in every cycle while the input side is not held off: the
// byte sits in the input register, and its results are written into the result
// queue once the queue has room for two, and the queue offers them in order on
// the result channel. The input side is held off only while the result queue
// lacks room for two results, which with the default depth of four happens only
// when the result side stalls. Reset is synchronous and active low; no clearing
// pass is needed.
// Depends on trd_pkg, trd_if, trd_parser and trd_rqueue.
`default_nettype none

module telegram_response_deframer #(
  parameter int RES_DEPTH = trd_pkg::RES_DEPTH
) (
  input  wire      clk,
  input  wire      rst_n,
  trd_in_if.sink   in_ch,
  trd_out_if.source out_ch
);

  // Results of the byte in the input register, valid only when it is consumed.
  trd_pkg::trd_push_t push;
  // The queue can take two more results this cycle.
  logic room2;

  trd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room2 (room2),
    .push  (push)
  );

  trd_rqueue #(
    .DEPTH (RES_DEPTH)
  ) u_rqueue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room2  (room2),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
